// ----- hdl/sbac_pkg.sv -----
package sbac_pkg;

	localparam int BATCH_CAPACITY = 8;
	localparam int COUNT_W = $clog2(BATCH_CAPACITY + 1);
	localparam int SAMPLE_W = 16;
	localparam int SUM_W = SAMPLE_W + $clog2(BATCH_CAPACITY + 1);
	localparam int SEQ_W = 32;
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);

	localparam logic [2:0] CMD_REINIT = 3'd0;
	localparam logic [2:0] CMD_START  = 3'd1;
	localparam logic [2:0] CMD_STOP   = 3'd2;
	localparam logic [2:0] CMD_SAMPLE = 3'd3;
	localparam logic [2:0] CMD_DMA    = 3'd4;
	localparam logic [2:0] CMD_RUN    = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_ARG   = 3'd1;
	localparam logic [2:0] ST_BAD_STATE = 3'd2;
	localparam logic [2:0] ST_NO_DATA   = 3'd3;
	localparam logic [2:0] ST_INTERNAL  = 3'd4;

	localparam logic [2:0] M_IDLE     = 3'd0;
	localparam logic [2:0] M_STARTING = 3'd1;
	localparam logic [2:0] M_RUNNING  = 3'd2;
	localparam logic [2:0] M_STOPPING = 3'd3;
	localparam logic [2:0] M_FAULT    = 3'd4;

	typedef struct packed {
		logic exec;
		logic div_step;
	} sbac_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} sbac_sts_t;

endpackage

// ----- hdl/sbac_ctrl.sv -----
module sbac_ctrl
	import sbac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  sbac_sts_t sts,
	output sbac_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready     = in_ready_q;
	assign out_valid    = out_valid_q;
	assign cmd.exec     = in_valid & in_ready_q;
	assign cmd.div_step = (state_q == S_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_ready_q <= 1'b0;
						if (sts.need_div) begin
							state_q <= S_DIV;
						end else begin
							state_q     <= S_OUT;
							out_valid_q <= 1'b1;
						end
					end
				end
				S_DIV: begin
					if (sts.div_done) begin
						state_q     <= S_OUT;
						out_valid_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	a_ready_valid_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready and result valid both high");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready stayed high after a request");

	a_deliver_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> (in_ready && !out_valid))
		else $error("block not idle after result delivered");

	a_div_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (!out_valid && !in_ready))
		else $error("divide step while a handshake is open");

endmodule

// ----- hdl/sbac_datapath.sv -----
module sbac_datapath
	import sbac_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  sbac_cmd_t           cmd,
	output sbac_sts_t           sts,
	input  logic [2:0]          command,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  logic                batch_last,
	input  logic [SEQ_W-1:0]    completion_sequence,
	output logic [2:0]          status_code,
	output logic                average_valid,
	output logic [SAMPLE_W-1:0] average_value,
	output logic [2:0]          machine_state,
	output logic [2:0]          recorded_status,
	output logic [SEQ_W-1:0]    latest_sequence,
	output logic [COUNT_W-1:0]  committed_count
);

	logic [2:0]         mode_q, mode_nxt;
	logic [2:0]         last_q, last_nxt;
	logic [SEQ_W-1:0]   seq_q, seq_nxt;
	logic               pend_q, pend_nxt;
	logic [SUM_W-1:0]   bsum_q, bsum_nxt;
	logic [COUNT_W-1:0] bcnt_q, bcnt_nxt;
	logic [SUM_W-1:0]   ssum_q, ssum_nxt;
	logic [COUNT_W-1:0] scnt_q, scnt_nxt;
	logic               sovf_q, sovf_nxt;
	logic [SUM_W-1:0]   add_sum;
	logic [COUNT_W-1:0] add_cnt;
	logic               add_ovf;
	logic [2:0]         st;
	logic               need_div;

	logic [SUM_W-1:0]     quot_q, quot_nxt;
	logic [COUNT_W-1:0]   rem_q;
	logic [COUNT_W-1:0]   dvs_q;
	logic [DIV_CNT_W-1:0] dcnt_q;
	logic [COUNT_W:0]     trial;
	logic                 take;
	logic                 div_last;

	logic [2:0]          res_status_q;
	logic                res_avalid_q;
	logic [SAMPLE_W-1:0] res_avg_q;
	logic [2:0]          res_mode_q;
	logic [2:0]          res_last_q;
	logic [SEQ_W-1:0]    res_seq_q;
	logic [COUNT_W-1:0]  res_cnt_q;

	always_comb begin
		mode_nxt = mode_q;
		last_nxt = last_q;
		seq_nxt  = seq_q;
		pend_nxt = pend_q;
		bsum_nxt = bsum_q;
		bcnt_nxt = bcnt_q;
		ssum_nxt = ssum_q;
		scnt_nxt = scnt_q;
		sovf_nxt = sovf_q;
		st       = ST_OK;
		need_div = 1'b0;
		add_sum  = ssum_q;
		add_cnt  = scnt_q;
		add_ovf  = sovf_q;
		if (scnt_q < COUNT_W'(BATCH_CAPACITY)) begin
			add_sum = ssum_q + SUM_W'(sample_value);
			add_cnt = scnt_q + COUNT_W'(1);
		end else begin
			add_ovf = 1'b1;
		end
		unique case (command)
			CMD_REINIT: begin
				mode_nxt = M_IDLE;
				last_nxt = ST_OK;
				seq_nxt  = '0;
				pend_nxt = 1'b0;
				bsum_nxt = '0;
				bcnt_nxt = '0;
				ssum_nxt = '0;
				scnt_nxt = '0;
				sovf_nxt = 1'b0;
			end
			CMD_START: begin
				if (mode_q == M_IDLE) begin
					mode_nxt = M_STARTING;
				end else begin
					st = ST_BAD_STATE;
				end
				last_nxt = st;
			end
			CMD_STOP: begin
				if (mode_q == M_RUNNING) begin
					mode_nxt = M_STOPPING;
				end else begin
					st = ST_BAD_STATE;
				end
				last_nxt = st;
			end
			CMD_SAMPLE: begin
				if (batch_last) begin
					if (add_ovf || (add_cnt == '0)) begin
						st = ST_BAD_ARG;
					end else if (mode_q == M_RUNNING) begin
						bsum_nxt = add_sum;
						bcnt_nxt = add_cnt;
					end else begin
						st = ST_BAD_STATE;
					end
					last_nxt = st;
					ssum_nxt = '0;
					scnt_nxt = '0;
					sovf_nxt = 1'b0;
				end else begin
					ssum_nxt = add_sum;
					scnt_nxt = add_cnt;
					sovf_nxt = add_ovf;
				end
			end
			CMD_DMA: begin
				seq_nxt  = completion_sequence;
				pend_nxt = 1'b1;
			end
			CMD_RUN: begin
				case (mode_q) inside
					M_IDLE, M_FAULT: st = ST_BAD_STATE;
					M_STARTING: mode_nxt = M_RUNNING;
					M_RUNNING: begin
						if (pend_q && (bcnt_q != '0)) begin
							need_div = 1'b1;
							pend_nxt = 1'b0;
						end else begin
							st = ST_NO_DATA;
						end
					end
					M_STOPPING: begin
						bcnt_nxt = '0;
						bsum_nxt = '0;
						pend_nxt = 1'b0;
						mode_nxt = M_IDLE;
					end
					default: begin
						mode_nxt = M_FAULT;
						st       = ST_INTERNAL;
					end
				endcase
				last_nxt = st;
			end
			default: st = ST_BAD_ARG;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			last_q <= ST_OK;
			seq_q  <= '0;
			pend_q <= 1'b0;
			bsum_q <= '0;
			bcnt_q <= '0;
			ssum_q <= '0;
			scnt_q <= '0;
			sovf_q <= 1'b0;
		end else if (cmd.exec) begin
			mode_q <= mode_nxt;
			last_q <= last_nxt;
			seq_q  <= seq_nxt;
			pend_q <= pend_nxt;
			bsum_q <= bsum_nxt;
			bcnt_q <= bcnt_nxt;
			ssum_q <= ssum_nxt;
			scnt_q <= scnt_nxt;
			sovf_q <= sovf_nxt;
		end
	end

	assign trial    = {rem_q, quot_q[SUM_W-1]};
	assign take     = (trial >= {1'b0, dvs_q});
	assign quot_nxt = {quot_q[SUM_W-2:0], take};
	assign div_last = (dcnt_q == DIV_CNT_W'(SUM_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			quot_q <= bsum_q;
			dvs_q  <= bcnt_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			quot_q <= quot_nxt;
			rem_q  <= take ? COUNT_W'(trial - {1'b0, dvs_q}) : COUNT_W'(trial);
			dcnt_q <= dcnt_q + DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= st;
			res_avalid_q <= need_div;
			res_avg_q    <= '0;
			res_mode_q   <= mode_nxt;
			res_last_q   <= last_nxt;
			res_seq_q    <= seq_nxt;
			res_cnt_q    <= bcnt_nxt;
		end else if (cmd.div_step && div_last) begin
			res_avg_q <= quot_nxt[SAMPLE_W-1:0];
		end
	end

	assign sts.need_div = need_div;
	assign sts.div_done = cmd.div_step & div_last;

	assign status_code     = res_status_q;
	assign average_valid   = res_avalid_q;
	assign average_value   = res_avg_q;
	assign machine_state   = res_mode_q;
	assign recorded_status = res_last_q;
	assign latest_sequence = res_seq_q;
	assign committed_count = res_cnt_q;

endmodule

// ----- hdl/sample_batch_average_controller.sv -----
// Channel  Handshake               Payload
// in       in_valid / in_ready     command, sample_value, batch_last, completion_sequence
// out      out_valid / out_ready   status_code, average_valid, average_value, machine_state,
//                                  recorded_status, latest_sequence, committed_count
//
// One request at a time. A request executes in its accept cycle; without a divide the
// result is valid on the next cycle. A run cycle that yields an average adds a
// restoring divide of the batch sum by its count (one quotient bit per cycle) before the result is valid.
// in_ready returns the cycle after the result is taken; a stalled result holds.
// arst_n clears control and batch state to idle at once; result and divider registers are not reset; no clearing pass.
module sample_batch_average_controller
	import sbac_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          command,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  logic                batch_last,
	input  logic [SEQ_W-1:0]    completion_sequence,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status_code,
	output logic                average_valid,
	output logic [SAMPLE_W-1:0] average_value,
	output logic [2:0]          machine_state,
	output logic [2:0]          recorded_status,
	output logic [SEQ_W-1:0]    latest_sequence,
	output logic [COUNT_W-1:0]  committed_count
);

	sbac_cmd_t cmd;
	sbac_sts_t sts;

	sbac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sbac_datapath u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.command             (command),
		.sample_value        (sample_value),
		.batch_last          (batch_last),
		.completion_sequence (completion_sequence),
		.status_code         (status_code),
		.average_valid       (average_valid),
		.average_value       (average_value),
		.machine_state       (machine_state),
		.recorded_status     (recorded_status),
		.latest_sequence     (latest_sequence),
		.committed_count     (committed_count)
	);

endmodule
